// ===== sv/fixed_buffer_pool_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed buffer pool allocator: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_BUFFER_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BUFFER_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FBPA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbpa: check failed");

// next-cycle implication
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbpa: check failed");

`endif

// ===== sv/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed buffer pool allocator package
// Widths, codes and defaults shared by the allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BUFFERS_DEF = 256;
  localparam int HEADER_BYTES    = 4;

  localparam int ADDR_W     = 32;
  localparam int PAYLOAD_W  = 16;
  localparam int STRIDE_W   = 17;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IDX_PORT_W = 8;
  localparam int CNT_PORT_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_CFG  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

endpackage

// ===== sv/fixed_buffer_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed buffer pool allocator
// LIFO free list of equal buffers, one link entry per buffer in a
// synchronous link memory.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     operation, buf_index, null_buffer
//  out      source     out_valid / out_stall   status, granted_index,
//                                              granted_address, free_count,
//                                              total_count
//  cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Alloc and free: beat in with the link read, then the read-modify-write
//  of the link entry. Init for a pool of n buffers: setup, then one link
//  write per buffer. One item is in flight at a time; a new beat is taken
//  while the last result waits in the output register.
//  Reset (rst, synchronous) empties the pool; the link memory is not cleared.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module fixed_buffer_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BUFFERS = MAX_BUFFERS_DEF  // 2 .. 256
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       operation,
  input  logic [IDX_PORT_W-1:0] buf_index,
  input  logic                  null_buffer,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [IDX_PORT_W-1:0] granted_index,
  output logic [ADDR_W-1:0]     granted_address,
  output logic [CNT_PORT_W-1:0] free_count,
  output logic [CNT_PORT_W-1:0] total_count,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  localparam int IDX_W  = $clog2(MAX_BUFFERS);
  localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
  localparam int LINK_W = $clog2(MAX_BUFFERS + 2);
  localparam int PROD_W = IDX_W + STRIDE_W;

  localparam logic [LINK_W-1:0] LINK_NULL  = LINK_W'(MAX_BUFFERS);
  localparam logic [LINK_W-1:0] LINK_TAKEN = LINK_W'(MAX_BUFFERS + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_BUFFERS);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(MAX_BUFFERS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SETUP = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t                state;
  op_t                   op_q;
  logic [IDX_PORT_W-1:0] idx_q;
  logic                  null_q;

  logic [LINK_W-1:0]     head;
  logic [CNT_W-1:0]      free_buffers;
  logic [CNT_W-1:0]      pool_buffers;
  logic [ADDR_W-1:0]     held_base;
  logic [STRIDE_W-1:0]   held_stride;

  logic [ADDR_W-1:0]     base_address;
  logic [ADDR_W-1:0]     area_bytes;
  logic [PAYLOAD_W-1:0]  payload_bytes;

  logic [ADDR_W-1:0]     rem;
  logic [IDX_W-1:0]      walk_idx;

  logic [STATUS_W-1:0]   status_r;
  logic [IDX_PORT_W-1:0] gidx_r;
  logic [ADDR_W-1:0]     gaddr_r;

  logic [LINK_W-1:0]     link_mem [MAX_BUFFERS];
  logic [LINK_W-1:0]     rd_data;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [LINK_W-1:0]     mem_wdata;

  logic                  accept_in;
  logic                  out_free;
  logic                  head_ok;
  logic                  free_ok;
  logic [PROD_W-1:0]     prod;
  logic [STRIDE_W-1:0]   stride_c;
  logic                  bad_cfg;
  logic                  area_lt_stride;
  logic                  walk_more;
  logic                  walk_step;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign status          = status_r;
  assign granted_index   = gidx_r;
  assign granted_address = gaddr_r;
  assign free_count      = CNT_PORT_W'(free_buffers);
  assign total_count     = CNT_PORT_W'(pool_buffers);

  assign head_ok  = (head < LINK_NULL);
  assign free_ok  = ({1'b0, idx_q} < CNT_PORT_W'(pool_buffers)) && (rd_data != LINK_NULL);
  assign prod     = head[IDX_W-1:0] * held_stride;

  assign stride_c       = STRIDE_W'(payload_bytes) + STRIDE_W'(HEADER_BYTES);
  assign bad_cfg        = (payload_bytes == '0) || (area_bytes < ADDR_W'(payload_bytes));
  assign area_lt_stride = (area_bytes < ADDR_W'(stride_c));

  assign walk_more = (rem >= ADDR_W'(held_stride)) && (walk_idx != IDX_LAST);
  assign walk_step = (state == S_WALK) && (walk_more || out_free);

  assign mem_re    = accept_in;
  assign mem_raddr = (op_t'(operation) == OP_ALLOC) ? head[IDX_W-1:0]
                                                    : buf_index[IDX_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head[IDX_W-1:0];
    mem_wdata = LINK_TAKEN;
    if (state == S_EXEC && out_free) begin
      if (op_q == OP_ALLOC && head_ok) begin
        mem_we = 1'b1;
      end else if (op_q == OP_FREE && !null_q && free_ok) begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IDX_W-1:0];
        mem_wdata = head;
      end
    end else if (walk_step) begin
      mem_we    = 1'b1;
      mem_waddr = walk_idx;
      mem_wdata = walk_more ? (LINK_W'(walk_idx) + LINK_W'(1)) : LINK_NULL;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      area_bytes    <= '0;
      payload_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE:    base_address  <= cfg_data;
        CFG_AREA:    area_bytes    <= cfg_data;
        CFG_PAYLOAD: payload_bytes <= cfg_data[PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      head         <= LINK_NULL;
      free_buffers <= '0;
      pool_buffers <= '0;
      held_base    <= '0;
      held_stride  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            op_q   <= op_t'(operation);
            idx_q  <= buf_index;
            null_q <= null_buffer;
            state  <= (op_t'(operation) == OP_INIT) ? S_SETUP : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status_r  <= ST_OK;
            gidx_r    <= '0;
            gaddr_r   <= '0;
            case (op_q)
              OP_ALLOC: begin
                if (head_ok) begin
                  head    <= rd_data;
                  gidx_r  <= IDX_PORT_W'(head[IDX_W-1:0]);
                  gaddr_r <= held_base + ADDR_W'(prod) + ADDR_W'(HEADER_BYTES);
                  if (free_buffers != '0) begin
                    free_buffers <= free_buffers - CNT_W'(1);
                  end
                end else begin
                  status_r <= ST_EMPTY;
                end
              end
              OP_FREE: begin
                if (!null_q) begin
                  if (free_ok) begin
                    head <= LINK_W'(idx_q[IDX_W-1:0]);
                    if (free_buffers != CNT_MAX) begin
                      free_buffers <= free_buffers + CNT_W'(1);
                    end
                  end else begin
                    status_r <= ST_BAD_FREE;
                  end
                end
              end
              default: ;
            endcase
            state <= S_IDLE;
          end
        end
        S_SETUP: begin
          held_base   <= base_address;
          held_stride <= stride_c;
          if (bad_cfg || base_address == '0) begin
            if (out_free) begin
              head         <= LINK_NULL;
              free_buffers <= '0;
              pool_buffers <= '0;
              out_valid    <= 1'b1;
              status_r     <= bad_cfg ? ST_BAD_CFG : ST_OK;
              gidx_r       <= '0;
              gaddr_r      <= '0;
              state        <= S_IDLE;
            end
          end else begin
            rem      <= area_lt_stride ? '0 : (area_bytes - ADDR_W'(stride_c));
            walk_idx <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_step) begin
            walk_idx <= walk_idx + IDX_W'(1);
            rem      <= rem - ADDR_W'(held_stride);
            if (!walk_more) begin
              head         <= '0;
              free_buffers <= CNT_W'(walk_idx) + CNT_W'(1);
              pool_buffers <= CNT_W'(walk_idx) + CNT_W'(1);
              out_valid    <= 1'b1;
              status_r     <= ST_OK;
              gidx_r       <= '0;
              gaddr_r      <= '0;
              state        <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "fixed_buffer_pool_allocator_defines.svh"

  // one item in flight
  `FBPA_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall)
  // a new result only comes out of a busy block
  `FBPA_ASSERT_IMPLIES(a_result_src, clk, rst, $rose(out_valid), $past(state) != S_IDLE)

endmodule
